// File: rtl/dif_pkg.sv
// Shared constants for the single-ion diffusivity core.
// No dependencies; used by single_ion_diffusivity_core and dif_div.
package dif_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_OHMIC     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALL      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMBIPOLAR = 2'd2;

	// flags leaving a divider pipe
	typedef struct packed {
		logic sat;      // quotient above the output range
		logic den_zero; // divisor was zero
	} div_flags_t;

endpackage

// File: rtl/dif_in_if.sv
// Input channel of the diffusivity core: one grid cell per word.
// Depends on nothing.
interface dif_in_if #(parameter int DATA_WIDTH = 32);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] field_x;
	logic signed [DATA_WIDTH-1:0] field_y;
	logic signed [DATA_WIDTH-1:0] field_z;
	logic        [DATA_WIDTH-2:0] density;

	modport source(output valid, field_x, field_y, field_z, density, input ready);
	modport sink(input valid, field_x, field_y, field_z, density, output ready);
endinterface

// File: rtl/dif_out_if.sv
// Output channel of the diffusivity core: one result word per cell.
// Depends on nothing.
interface dif_out_if #(parameter int DATA_WIDTH = 32);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-2:0] ohmic_eta;
	logic [DATA_WIDTH-2:0] hall_eta;
	logic [DATA_WIDTH-2:0] ambipolar_eta;
	logic                  saturated;

	modport source(output valid, ohmic_eta, hall_eta, ambipolar_eta, saturated, input ready);
	modport sink(input valid, ohmic_eta, hall_eta, ambipolar_eta, saturated, output ready);
endinterface

// File: rtl/single_ion_diffusivity_core.sv
// Single-ion magnetic diffusivity core, top level.
// Depends on dif_pkg, dif_in_if, dif_out_if, dif_sqrt and dif_div.
//
// Takes one grid cell word (Bx, By, Bz signed, density unsigned) per clock and returns
// one result word per cell, in order: the configured Ohmic diffusivity, the Hall
// diffusivity hall_coefficient*floor(sqrt(|B|^2))/density and the ambipolar diffusivity
// ambipolar_coefficient*|B|^2/density^2, both floored and clamped to the largest
// DATA_WIDTH-1 bit value; saturated marks a clamp or a zero density. A coefficient of
// zero gives a zero output. Throughput is one cell per cycle unless stalled.
// Most of the pipe is the bit-per-stage square root (DATA_WIDTH+1 stages) followed by
// the bit-per-stage dividers (DATA_WIDTH stages). The whole pipe advances together: it
// holds only while a finished result waits at the output register. The user must
// write configuration through cfg_we/cfg_index/cfg_data only while no cell is in
// flight (not enforced by the block); indexes outside the register list are ignored.
module single_ion_diffusivity_core #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [dif_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [DATA_WIDTH-2:0]                 cfg_data,
	dif_in_if.sink                                grid_cell,
	dif_out_if.source                             result
);
	localparam int W   = DATA_WIDTH;
	localparam int SQW = 2 * W;          // |B|^2
	localparam int D2W = 2 * W - 2;      // density^2
	localparam int HNW = 2 * W - 1;      // Hall numerator
	localparam int ANW = 3 * W - 1;      // ambipolar numerator
	localparam int TGW = SQW + (W - 1) + D2W;
	localparam logic [W-2:0] MAX_VAL = '1;

	// ---------------- configuration registers ----------------
	logic [W-2:0] ohm_q, hall_coef_q, amb_coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ohm_q       <= '0;
			hall_coef_q <= '0;
			amb_coef_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dif_pkg::REG_OHMIC:     ohm_q       <= cfg_data;
				dif_pkg::REG_HALL:      hall_coef_q <= cfg_data;
				dif_pkg::REG_AMBIPOLAR: amb_coef_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// one enable for the whole pipe: advance unless a result is stuck at the output
	logic en;
	assign en              = !result.valid || result.ready;
	assign grid_cell.ready = en;

	// ---------------- s1: field magnitudes ----------------
	logic         v_s1;
	logic [W-1:0] mx_s1, my_s1, mz_s1;
	logic [W-2:0] d_s1;

	// most negative value negates to 2^(W-1), which still fits W unsigned bits
	function automatic logic [W-1:0] mag(input logic [W-1:0] raw);
		mag = raw[W-1] ? (~raw + 1'b1) : raw;
	endfunction

	// ---------------- s2: squares ----------------
	logic           v_s2;
	logic [SQW-1:0] sx_s2, sy_s2, sz_s2;
	logic [D2W-1:0] d2_s2;
	logic [W-2:0]   d_s2;

	// ---------------- s3: |B|^2 ----------------
	logic           v_s3;
	logic [SQW-1:0] bsq_s3;
	logic [D2W-1:0] d2_s3;
	logic [W-2:0]   d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= grid_cell.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1  <= mag(grid_cell.field_x);
			my_s1  <= mag(grid_cell.field_y);
			mz_s1  <= mag(grid_cell.field_z);
			d_s1   <= grid_cell.density;
			sx_s2  <= SQW'(mx_s1) * SQW'(mx_s1);
			sy_s2  <= SQW'(my_s1) * SQW'(my_s1);
			sz_s2  <= SQW'(mz_s1) * SQW'(mz_s1);
			d2_s2  <= D2W'(d_s1) * D2W'(d_s1);
			d_s2   <= d_s1;
			// three squares of at most 2^(2W-2) stay below 2^(2W)
			bsq_s3 <= sx_s2 + sy_s2 + sz_s2;
			d2_s3  <= d2_s2;
			d_s3   <= d_s2;
		end
	end

	// ---------------- square root ----------------
	logic           v_sq;
	logic [W-1:0]   bmag_sq;
	logic [TGW-1:0] tag_sq;
	logic [SQW-1:0] bsq_sq;
	logic [W-2:0]   d_sq;
	logic [D2W-1:0] d2_sq;

	dif_sqrt #(
		.ROOT_W(W),
		.TAG_W (TGW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.value    (bsq_s3),
		.in_tag   ({bsq_s3, d_s3, d2_s3}),
		.out_valid(v_sq),
		.root     (bmag_sq),
		.out_tag  (tag_sq)
	);

	assign {bsq_sq, d_sq, d2_sq} = tag_sq;

	// ---------------- m1/m2: numerators ----------------
	// coefficient * |B|^2 is cut into two W-bit halves of |B|^2
	logic           v_m1, v_m2;
	logic [HNW-1:0] hnum_m1, hnum_m2;
	logic [HNW-1:0] alo_m1, ahi_m1;
	logic [ANW-1:0] anum_m2;
	logic [W-2:0]   d_m1, d_m2;
	logic [D2W-1:0] d2_m1, d2_m2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
		end else if (en) begin
			v_m1 <= v_sq;
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hnum_m1 <= HNW'(hall_coef_q) * HNW'(bmag_sq);
			alo_m1  <= HNW'(amb_coef_q) * HNW'(bsq_sq[W-1:0]);
			ahi_m1  <= HNW'(amb_coef_q) * HNW'(bsq_sq[SQW-1:W]);
			d_m1    <= d_sq;
			d2_m1   <= d2_sq;
			hnum_m2 <= hnum_m1;
			anum_m2 <= {ahi_m1, {W{1'b0}}} + ANW'(alo_m1);
			d_m2    <= d_m1;
			d2_m2   <= d2_m1;
		end
	end

	// ---------------- dividers ----------------
	logic                v_hd, v_ad;
	logic [W-2:0]        hq, aq;
	dif_pkg::div_flags_t hfl, afl;

	dif_div #(
		.NUM_W (HNW),
		.DEN_W (W - 1),
		.QUOT_W(W - 1)
	) u_hall_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_m2),
		.num      (hnum_m2),
		.den      (d_m2),
		.out_valid(v_hd),
		.quot     (hq),
		.flags    (hfl)
	);

	// floor(floor(x/d)/d) equals floor(x/d^2), so one divide by d^2 suffices
	dif_div #(
		.NUM_W (ANW),
		.DEN_W (D2W),
		.QUOT_W(W - 1)
	) u_amb_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_m2),
		.num      (anum_m2),
		.den      (d2_m2),
		.out_valid(v_ad),
		.quot     (aq),
		.flags    (afl)
	);

	// ---------------- output register ----------------
	logic hall_on, amb_on;
	assign hall_on = hall_coef_q != '0;
	assign amb_on  = amb_coef_q != '0;

	logic         v_o_q;
	logic [W-2:0] hall_q, amb_q;
	logic         sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o_q <= 1'b0;
		end else if (en) begin
			v_o_q <= v_hd && v_ad;
		end
	end

	// zero density always saturates a divider, which gives the clamp value unless that coefficient is zero
	always_ff @(posedge clk) begin
		if (en) begin
			hall_q <= !hall_on ? '0 : (hfl.sat ? MAX_VAL : hq);
			amb_q  <= !amb_on ? '0 : (afl.sat ? MAX_VAL : aq);
			sat_q  <= hfl.den_zero || afl.den_zero || (hall_on && hfl.sat)
				|| (amb_on && afl.sat);
		end
	end

	assign result.valid         = v_o_q;
	assign result.ohmic_eta     = ohm_q;
	assign result.hall_eta      = hall_q;
	assign result.ambipolar_eta = amb_q;
	assign result.saturated     = sat_q;
endmodule

// File: rtl/dif_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband tag.
// Depends on nothing; used by single_ion_diffusivity_core.
module dif_sqrt #(
	parameter int ROOT_W = 32,
	parameter int TAG_W  = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [2*ROOT_W-1:0]   value,
	input  logic [TAG_W-1:0]      in_tag,
	output logic                  out_valid,
	output logic [ROOT_W-1:0]     root,
	output logic [TAG_W-1:0]      out_tag
);
	localparam int RW = ROOT_W + 3;

	logic                v_s   [0:ROOT_W];
	logic [2*ROOT_W-1:0] val_s [0:ROOT_W];
	logic [RW-1:0]       rem_s [0:ROOT_W];
	logic [ROOT_W-1:0]   rt_s  [0:ROOT_W];
	logic [TAG_W-1:0]    tag_s [0:ROOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s[0] <= value;
			rem_s[0] <= '0;
			rt_s[0]  <= '0;
			tag_s[0] <= in_tag;
		end
	end

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_stage
		logic [RW-1:0] cur;
		logic [RW-1:0] trial;
		logic          ge;

		// bring down the next two radicand bits, try root*4+1
		assign cur   = {rem_s[k-1][RW-3:0], val_s[k-1][2*ROOT_W-1 -: 2]};
		assign trial = {1'b0, rt_s[k-1], 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				val_s[k] <= {val_s[k-1][2*ROOT_W-3:0], 2'b00};
				rem_s[k] <= ge ? cur - trial : cur;
				rt_s[k]  <= {rt_s[k-1][ROOT_W-2:0], ge};
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign root      = rt_s[ROOT_W];
	assign out_tag   = tag_s[ROOT_W];
endmodule

// File: rtl/dif_div.sv
// Pipelined restoring divider with a QUOT_W-bit quotient and a saturation flag for overflow.
// Depends on dif_pkg; used by single_ion_diffusivity_core.
module dif_div #(
	parameter int NUM_W  = 63,
	parameter int DEN_W  = 31,
	parameter int QUOT_W = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [NUM_W-1:0]    num,
	input  logic [DEN_W-1:0]    den,
	output logic                out_valid,
	output logic [QUOT_W-1:0]   quot,
	output dif_pkg::div_flags_t flags
);
	localparam int HW = NUM_W - QUOT_W;

	logic              v_s    [0:QUOT_W];
	logic [DEN_W-1:0]  rem_s  [0:QUOT_W];
	logic [QUOT_W-1:0] bits_s [0:QUOT_W];
	logic [DEN_W-1:0]  den_s  [0:QUOT_W];
	dif_pkg::div_flags_t fl_s [0:QUOT_W];

	logic [HW-1:0] hi;
	logic          sat;

	// quotient overflows exactly when the top part already reaches the divisor
	assign hi  = num[NUM_W-1:QUOT_W];
	assign sat = hi >= HW'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]           <= sat ? '0 : hi[DEN_W-1:0];
			bits_s[0]          <= num[QUOT_W-1:0];
			den_s[0]           <= den;
			fl_s[0].sat        <= sat;
			fl_s[0].den_zero   <= den == '0;
		end
	end

	for (genvar k = 1; k <= QUOT_W; k++) begin : g_stage
		logic [DEN_W:0] cur;
		logic [DEN_W:0] diff;
		logic           ge;

		assign cur  = {rem_s[k-1], bits_s[k-1][QUOT_W-1]};
		assign ge   = cur >= {1'b0, den_s[k-1]};
		assign diff = cur - {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
				bits_s[k] <= {bits_s[k-1][QUOT_W-2:0], ge};
				den_s[k]  <= den_s[k-1];
				fl_s[k]   <= fl_s[k-1];
			end
		end
	end

	assign out_valid = v_s[QUOT_W];
	assign quot      = bits_s[QUOT_W];
	assign flags     = fl_s[QUOT_W];
endmodule

// File: tb/tb_single_ion_diffusivity_core.sv
// Self-checking testbench for single_ion_diffusivity_core.
// Depends on dif_pkg, dif_in_if, dif_out_if and the core RTL; drives cells,
// predicts Ohmic/Hall/ambipolar diffusivities and checks every result word.
`timescale 1ns / 1ps

module tb_single_ion_diffusivity_core;

	localparam int DW = 32;
	localparam logic [DW-2:0] ETA_MAX = {(DW-1){1'b1}};
	// no register behind this index; writes to it must do nothing
	localparam logic [dif_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	// pipe depth plus margin
	localparam int DRAIN_CYCLES = 2*DW + 20;
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_CELLS = 850;
	localparam int PHASES = 8;

	typedef struct packed {
		logic signed [DW-1:0] bx;
		logic signed [DW-1:0] by;
		logic signed [DW-1:0] bz;
		logic [DW-2:0]        dens;
	} cell_t;

	typedef struct packed {
		logic [DW-2:0] ohm;
		logic [DW-2:0] hall;
		logic [DW-2:0] amb;
		logic          sat;
	} eta_t;

	typedef struct packed {
		logic [DW-2:0] ohm;
		logic [DW-2:0] hall;
		logic [DW-2:0] amb;
	} coef_t;

	// directed row: coefficient set, cell, and optionally a hand-read answer
	typedef struct packed {
		logic [2:0] set;
		cell_t      c;
		logic       typed;
		logic [DW-2:0] hall;
		logic [DW-2:0] amb;
		logic       sat;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [dif_pkg::CFG_IDX_W-1:0] cfg_index = dif_pkg::REG_OHMIC;
	logic [DW-2:0] cfg_data = '0;

	dif_in_if #(.DATA_WIDTH(DW)) cell_ch ();
	dif_out_if #(.DATA_WIDTH(DW)) eta_ch ();

	single_ion_diffusivity_core #(.DATA_WIDTH(DW)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .grid_cell(cell_ch.sink), .result(eta_ch.source)
	);

	always #5 clk = ~clk;

	// shadow of the core's registers
	coef_t coef = '0;
	eta_t eta_q[$];
	int n_cells = 0, n_words = 0, n_bad = 0, n_sat = 0, idle = 0;

	coef_t sets[5];
	row_t rows[$];

	function automatic logic [127:0] field_mag(logic signed [DW-1:0] v);
		// most negative value maps to 2^(DW-1) exactly
		return v[DW-1] ? 128'(~v) + 128'd1 : 128'(v);
	endfunction

	// expected diffusivities of one cell under the current coefficients
	function automatic eta_t diffusivity(cell_t c);
		eta_t r;
		logic [127:0] bsq, root, trial, q;
		r = '0;
		r.ohm = coef.ohm;
		r.sat = (c.dens == 0);
		bsq = field_mag(c.bx) * field_mag(c.bx) + field_mag(c.by) * field_mag(c.by)
			+ field_mag(c.bz) * field_mag(c.bz);
		root = '0;
		for (int b = DW - 1; b >= 0; b--) begin
			trial = root | (128'd1 << b);
			if (trial * trial <= bsq)
				root = trial;
		end
		if (coef.hall != 0) begin
			if (c.dens == 0) begin
				r.hall = ETA_MAX;
			end else begin
				q = (128'(coef.hall) * root) / 128'(c.dens);
				if (q > 128'(ETA_MAX)) begin
					r.hall = ETA_MAX;
					r.sat = 1'b1;
				end else begin
					r.hall = q[DW-2:0];
				end
			end
		end
		if (coef.amb != 0) begin
			if (c.dens == 0) begin
				r.amb = ETA_MAX;
			end else begin
				q = (128'(coef.amb) * bsq) / (128'(c.dens) * 128'(c.dens));
				if (q > 128'(ETA_MAX)) begin
					r.amb = ETA_MAX;
					r.sat = 1'b1;
				end else begin
					r.amb = q[DW-2:0];
				end
			end
		end
		return r;
	endfunction

	task automatic write_reg(logic [dif_pkg::CFG_IDX_W-1:0] idx, logic [DW-2:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		unique case (idx)
			dif_pkg::REG_OHMIC:     coef.ohm = val;
			dif_pkg::REG_HALL:      coef.hall = val;
			dif_pkg::REG_AMBIPOLAR: coef.amb = val;
			default: ;
		endcase
	endtask

	// wait for the pipe to empty, then let it settle before touching registers
	task automatic drain();
		while (eta_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic load_coefs(coef_t k);
		drain();
		write_reg(dif_pkg::REG_OHMIC, k.ohm);
		write_reg(dif_pkg::REG_HALL, k.hall);
		write_reg(dif_pkg::REG_AMBIPOLAR, k.amb);
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// push one cell; when typed, the hand-read answer replaces the prediction
	task automatic send_cell(cell_t c, bit typed, eta_t hand);
		eta_t e;
		repeat (gap_len()) @(negedge clk);
		cell_ch.valid = 1'b1;
		cell_ch.field_x = c.bx;
		cell_ch.field_y = c.by;
		cell_ch.field_z = c.bz;
		cell_ch.density = c.dens;
		do @(posedge clk); while (!cell_ch.ready);
		e = typed ? hand : diffusivity(c);
		eta_q.push_back(e);
		n_cells++;
		@(negedge clk);
		cell_ch.valid = 1'b0;
	endtask

	function automatic logic signed [DW-1:0] rand_field();
		case ($urandom_range(0, 5))
			0: return $signed(DW'($urandom_range(0, 1 << 20))) * ($urandom_range(0, 1) ? 1 : -1);
			1: return {1'b1, {(DW-1){1'b0}}};
			2: return {1'b0, {(DW-1){1'b1}}};
			3: return $signed(DW'($urandom_range(0, 1 << 26))) * ($urandom_range(0, 1) ? 1 : -1);
			default: return $signed($urandom());
		endcase
	endfunction

	function automatic logic [DW-2:0] rand_dens();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ETA_MAX;
			2, 3: return (DW-1)'($urandom_range(1, 1 << 18));
			4: return (DW-1)'($urandom_range(1 << 16, 1 << 24));
			default: return (DW-1)'($urandom());
		endcase
	endfunction

	function automatic logic [DW-2:0] rand_coef();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return ETA_MAX;
			2: return (DW-1)'($urandom_range(1, 1 << 20));
			default: return (DW-1)'($urandom());
		endcase
	endfunction

	// result side: random backpressure, mostly short stalls with a few long ones
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			eta_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 25) begin
			stall_left <= gap_len();
			eta_ch.ready <= 1'b0;
		end else begin
			eta_ch.ready <= 1'b1;
		end
	end

	// compare each accepted result word with the oldest prediction
	always @(posedge clk) begin
		eta_t got, want;
		if (arst_n && eta_ch.valid && eta_ch.ready) begin
			got = {eta_ch.ohmic_eta, eta_ch.hall_eta, eta_ch.ambipolar_eta, eta_ch.saturated};
			n_words++;
			if (got.sat) n_sat++;
			if (eta_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("ERROR: unexpected result word %h", got);
			end else begin
				want = eta_q.pop_front();
				if (got !== want) begin
					n_bad++;
					if (n_bad <= 10)
						$display("ERROR: word %0d ohm %h/%h hall %h/%h amb %h/%h sat %b/%b",
							n_words, want.ohm, got.ohm, want.hall, got.hall,
							want.amb, got.amb, want.sat, got.sat);
				end
			end
		end
	end

	// watchdog: a stretch without a handshake on either side that reaches IDLE_LIMIT is a hang
	always @(posedge clk) begin
		if ((cell_ch.valid && cell_ch.ready) || (eta_ch.valid && eta_ch.ready))
			idle <= 0;
		else
			idle <= idle + 1;
		if (idle >= IDLE_LIMIT) begin
			$display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		row_t rw;
		eta_t hand;
		int cur_set;
		cell_ch.valid = 1'b0;
		cell_ch.field_x = '0;
		cell_ch.field_y = '0;
		cell_ch.field_z = '0;
		cell_ch.density = '0;

		// 0: reset values, 1: all extremes, 2: unit coefficients,
		// 3: Hall only, 4: ambipolar only
		sets[0] = '0;
		sets[1] = {ETA_MAX, ETA_MAX, ETA_MAX};
		sets[2] = {31'd12345, 31'h10000, 31'h10000};
		sets[3] = {31'd1, 31'h7fff, 31'd0};
		sets[4] = {31'd0, 31'd0, 31'h30000};

		// reset values: both terms off, flag only from zero density
		rows.push_back({3'd0, {32'sd1 <<< 16, 32'sd0, 32'sd0, 31'h10000}, 1'b1, 31'd0, 31'd0, 1'b0});
		rows.push_back({3'd0, {32'sh7fffffff, 32'sh80000000, 32'sd5, 31'd0}, 1'b1, 31'd0, 31'd0, 1'b1});
		// extremes: zero density and the most negative field both clamp
		rows.push_back({3'd1, {32'sd0, 32'sd0, 32'sd0, 31'd0}, 1'b1, ETA_MAX, ETA_MAX, 1'b1});
		rows.push_back({3'd1, {32'sh80000000, 32'sh80000000, 32'sh80000000, 31'd1}, 1'b1,
			ETA_MAX, ETA_MAX, 1'b1});
		rows.push_back({3'd1, {32'sd0, 32'sd0, 32'sd0, ETA_MAX}, 1'b1, 31'd0, 31'd0, 1'b0});
		rows.push_back({3'd1, {32'sd1, 32'sd0, 32'sd0, ETA_MAX}, 1'b0, 31'd0, 31'd0, 1'b0});
		rows.push_back({3'd1, {32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, ETA_MAX}, 1'b0,
			31'd0, 31'd0, 1'b0});
		// unit coefficients: exact-looking cases and zero field
		rows.push_back({3'd2, {32'sd0, 32'sd0, 32'sd0, 31'h10000}, 1'b1, 31'd0, 31'd0, 1'b0});
		rows.push_back({3'd2, {32'sh30000, -32'sh40000, 32'sd0, 31'h10000}, 1'b0, 31'd0, 31'd0, 1'b0});
		rows.push_back({3'd2, {-32'sd1, -32'sd1, -32'sd1, 31'd1}, 1'b0, 31'd0, 31'd0, 1'b0});
		rows.push_back({3'd2, {32'sh80000000, 32'sd0, 32'sd0, 31'h7fffffff}, 1'b0, 31'd0, 31'd0, 1'b0});
		rows.push_back({3'd2, {32'sd0, 32'sd0, 32'sd0, 31'd0}, 1'b1, ETA_MAX, ETA_MAX, 1'b1});
		// one coefficient zero: that output stays zero, even at zero density
		rows.push_back({3'd3, {32'sd0, 32'sd0, 32'sd0, 31'd0}, 1'b1, ETA_MAX, 31'd0, 1'b1});
		rows.push_back({3'd3, {32'sh12345, -32'sh777, 32'sh10000, 31'h800}, 1'b0, 31'd0, 31'd0, 1'b0});
		rows.push_back({3'd4, {32'sd0, 32'sd0, 32'sd0, 31'd0}, 1'b1, 31'd0, ETA_MAX, 1'b1});
		rows.push_back({3'd4, {32'sh20000, 32'sh20000, -32'sh10000, 31'h18000}, 1'b0,
			31'd0, 31'd0, 1'b0});

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		cur_set = 0;
		foreach (rows[i]) begin
			rw = rows[i];
			if (rw.set != cur_set) begin
				cur_set = rw.set;
				load_coefs(sets[cur_set]);
				// index with no register behind it: must leave the set alone
				if (cur_set == 2)
					write_reg(REG_UNUSED, (DW-1)'($urandom()));
			end
			hand = {coef.ohm, rw.hall, rw.amb, rw.sat};
			send_cell(rw.c, rw.typed, hand);
		end

		// random part: fixed sets first, random coefficients after
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 5)
				load_coefs(sets[ph]);
			else
				load_coefs({rand_coef(), rand_coef(), rand_coef()});
			for (int k = 0; k < RANDOM_CELLS / PHASES; k++)
				send_cell({rand_field(), rand_field(), rand_field(), rand_dens()}, 1'b0, '0);
		end

		drain();
		$display("Sent %0d cells over %0d coefficient phases; %0d result words checked,",
			n_cells, PHASES + 5, n_words);
		$display("%0d of them flagged saturated, %0d mismatches.", n_sat, n_bad);
		if (n_bad == 0 && eta_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
rtl/dif_pkg.sv
rtl/dif_in_if.sv
rtl/dif_out_if.sv
rtl/dif_sqrt.sv
rtl/dif_div.sv
rtl/single_ion_diffusivity_core.sv
tb/tb_single_ion_diffusivity_core.sv
